// ===== rtl/gbnr_pkg.sv =====
// Package for the Go-Back-N receiver engine.
// Holds packet type codes, link state codes and the reply struct.
// Used by gbnr_core and go_back_n_receiver_engine.
`default_nettype none

package gbnr_pkg;

    // Packet type codes, shared by received headers and replies.
    typedef enum logic [2:0] {
        PKT_SYN    = 3'd0,
        PKT_SYNACK = 3'd1,
        PKT_ACK    = 3'd2,
        PKT_FIN    = 3'd3,
        PKT_FINACK = 3'd4,
        PKT_DATA   = 3'd5
    } pkt_type_t;

    // Connection states.
    typedef enum logic [2:0] {
        LS_LISTEN     = 3'd0,
        LS_WAIT_ACK   = 3'd1,
        LS_ESTAB      = 3'd2,
        LS_WAIT_FINAL = 3'd3,
        LS_CLOSED     = 3'd4
    } link_state_t;

    // Field widths of the stream items.
    localparam int unsigned TYPE_W    = 3;
    localparam int unsigned PSEQ_W    = 16;
    localparam int unsigned TICK_W    = 8;
    localparam int unsigned S_TDATA_W = 24;
    localparam int unsigned M_TDATA_W = 24;

    // Reset value of the timeout register.
    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 8'd5;

    // Control part of one result item (the sequence number travels apart).
    typedef struct packed {
        logic        send_valid;
        logic [2:0]  send_type;
        logic        deliver;
        link_state_t link_state;
    } reply_t;

endpackage

`default_nettype wire

// ===== rtl/gbnr_core.sv =====
// Step logic of the Go-Back-N receiver: next connection state and reply.
// Purely combinational; the state registers live in the top level.
// Depends on gbnr_pkg.
`default_nettype none

module gbnr_core #(
    parameter int unsigned SEQ_BITS = 16
) (
    input  wire logic                         tick,
    input  wire logic [2:0]                   pkt_type,
    input  wire logic [SEQ_BITS-1:0]          pkt_seq,
    input  wire logic                         checksum_ok,
    input  wire logic [gbnr_pkg::TICK_W-1:0]  timeout_ticks,
    input  wire gbnr_pkg::link_state_t        state_cur,
    input  wire logic [gbnr_pkg::TICK_W-1:0]  tick_cur,
    input  wire logic [SEQ_BITS-1:0]          reply_seq_cur,
    input  wire logic [SEQ_BITS-1:0]          expected_cur,
    output gbnr_pkg::link_state_t             state_next,
    output logic [gbnr_pkg::TICK_W-1:0]       tick_next,
    output logic [SEQ_BITS-1:0]               reply_seq_next,
    output logic [SEQ_BITS-1:0]               expected_next,
    output gbnr_pkg::reply_t                  reply,
    output logic [SEQ_BITS-1:0]               send_seq
);

    logic                           pkt;
    logic [gbnr_pkg::TICK_W:0]      tick_inc;
    logic                           expired;
    logic [SEQ_BITS-1:0]            seq_plus;
    logic [SEQ_BITS-1:0]            exp_plus;
    logic                           in_order;
    logic                           valid_ack;

    // Shared decode of the item.
    assign pkt       = !tick;
    assign tick_inc  = {1'b0, tick_cur} + (gbnr_pkg::TICK_W + 1)'(1);
    assign expired   = tick_inc >= {1'b0, timeout_ticks};
    assign seq_plus  = pkt_seq + SEQ_BITS'(1);
    assign exp_plus  = expected_cur + SEQ_BITS'(1);
    assign in_order  = pkt_seq == expected_cur;
    assign valid_ack = pkt && checksum_ok && (pkt_type == gbnr_pkg::PKT_ACK);

    // Next state of the connection and its counters.
    always_comb begin
        state_next     = state_cur;
        tick_next      = tick_cur;
        reply_seq_next = reply_seq_cur;
        expected_next  = expected_cur;
        unique case (state_cur)
            gbnr_pkg::LS_LISTEN: begin
                if (pkt && checksum_ok && pkt_type == gbnr_pkg::PKT_SYN) begin
                    reply_seq_next = seq_plus;
                    tick_next      = '0;
                    state_next     = gbnr_pkg::LS_WAIT_ACK;
                end
            end
            gbnr_pkg::LS_WAIT_ACK, gbnr_pkg::LS_WAIT_FINAL: begin
                if (tick) begin
                    tick_next = expired ? '0 : tick_inc[gbnr_pkg::TICK_W-1:0];
                end else begin
                    tick_next = '0;
                    if (valid_ack) begin
                        state_next = (state_cur == gbnr_pkg::LS_WAIT_ACK) ?
                                     gbnr_pkg::LS_ESTAB : gbnr_pkg::LS_CLOSED;
                    end
                end
            end
            gbnr_pkg::LS_ESTAB: begin
                if (pkt && checksum_ok) begin
                    if (pkt_type == gbnr_pkg::PKT_FIN) begin
                        reply_seq_next = seq_plus;
                        tick_next      = '0;
                        state_next     = gbnr_pkg::LS_WAIT_FINAL;
                    end else if (pkt_type == gbnr_pkg::PKT_DATA && in_order) begin
                        expected_next = exp_plus;
                    end
                end
            end
            default: begin
                state_next = gbnr_pkg::LS_CLOSED;
            end
        endcase
    end

    // Reply fields of the result item.
    always_comb begin
        reply.send_valid = 1'b0;
        reply.send_type  = '0;
        reply.deliver    = 1'b0;
        reply.link_state = state_next;
        send_seq         = '0;
        unique case (state_cur)
            gbnr_pkg::LS_LISTEN: begin
                if (pkt && checksum_ok && pkt_type == gbnr_pkg::PKT_SYN) begin
                    reply.send_valid = 1'b1;
                    reply.send_type  = gbnr_pkg::PKT_SYNACK;
                    send_seq         = seq_plus;
                end
            end
            gbnr_pkg::LS_WAIT_ACK, gbnr_pkg::LS_WAIT_FINAL: begin
                // Resend on timeout or on any packet but a valid ACK.
                if ((tick && expired) || (pkt && !valid_ack)) begin
                    reply.send_valid = 1'b1;
                    reply.send_type  = (state_cur == gbnr_pkg::LS_WAIT_ACK) ?
                                       gbnr_pkg::PKT_SYNACK : gbnr_pkg::PKT_FINACK;
                    send_seq         = reply_seq_cur;
                end
            end
            gbnr_pkg::LS_ESTAB: begin
                if (pkt && checksum_ok) begin
                    if (pkt_type == gbnr_pkg::PKT_FIN) begin
                        reply.send_valid = 1'b1;
                        reply.send_type  = gbnr_pkg::PKT_FINACK;
                        send_seq         = seq_plus;
                    end else if (pkt_type == gbnr_pkg::PKT_DATA) begin
                        // Acknowledge with the number still expected after this item.
                        reply.send_valid = 1'b1;
                        reply.send_type  = gbnr_pkg::PKT_ACK;
                        reply.deliver    = in_order;
                        send_seq         = in_order ? exp_plus : expected_cur;
                    end
                end
            end
            default: begin
                reply.send_valid = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/go_back_n_receiver_engine.sv =====
// Top level of the Go-Back-N receiver engine: input register, state and result register.
// Instantiates gbnr_core; depends on gbnr_pkg.
`default_nettype none

// The engine takes one item per cycle: a received packet header or a timer tick
// (s_tuser high). Each item yields exactly one result item once it is accepted: it
// sits in the input register, then the step logic updates the
// connection state and loads the result register. Back-to-back items see the
// state left by the one before them. s_tready stays high while the result register
// can drain, so full rate holds as long as m_tready is high. Sequence numbers are
// SEQ_BITS wide inside and wrap at 2^SEQ_BITS; the 16-bit header number is reduced
// to that width and the reply number is cut to 16 bits. Write timeout_ticks only
// while no item is in flight.
module go_back_n_receiver_engine #(
    parameter int unsigned SEQ_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Timeout register.
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,
    // Input items.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [2:0] pkt_type, [18:3] pkt_seq, [19] checksum_ok, [23:20] zero
    input  wire logic [23:0] s_tdata,
    // [0] cmd
    input  wire logic        s_tuser,
    // Result items.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [0] send_valid, [3:1] send_type, [19:4] send_seq, [20] deliver, [23:21] link_state
    output logic [23:0]      m_tdata
);

    localparam int unsigned PSEQ_W = gbnr_pkg::PSEQ_W;

    // Input register.
    logic                        in_valid_reg;
    logic                        in_tick_reg;
    logic [2:0]                  in_type_reg;
    logic [PSEQ_W-1:0]           in_seq_reg;
    logic                        in_ok_reg;

    // Connection state.
    gbnr_pkg::link_state_t       state_reg;
    gbnr_pkg::link_state_t       state_next;
    logic [gbnr_pkg::TICK_W-1:0] tick_reg;
    logic [gbnr_pkg::TICK_W-1:0] tick_next;
    logic [SEQ_BITS-1:0]         reply_seq_reg;
    logic [SEQ_BITS-1:0]         reply_seq_next;
    logic [SEQ_BITS-1:0]         expected_reg;
    logic [SEQ_BITS-1:0]         expected_next;
    logic [gbnr_pkg::TICK_W-1:0] timeout_reg;

    // Result register.
    logic                        out_valid_reg;
    logic [23:0]                 out_data_reg;

    logic                        out_free;
    logic                        step;
    logic [SEQ_BITS-1:0]         seq_in;
    logic [SEQ_BITS-1:0]         send_seq;
    logic [PSEQ_W-1:0]           send_seq16;
    gbnr_pkg::reply_t            reply;

    // Handshake: the result register drains or is empty.
    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Resize the header number to the internal width and the reply number back.
    always_comb begin
        seq_in     = '0;
        send_seq16 = '0;
        for (int i = 0; i < SEQ_BITS && i < PSEQ_W; i++) begin
            seq_in[i]     = in_seq_reg[i];
            send_seq16[i] = send_seq[i];
        end
    end

    gbnr_core #(
        .SEQ_BITS (SEQ_BITS)
    ) u_core (
        .tick           (in_tick_reg),
        .pkt_type       (in_type_reg),
        .pkt_seq        (seq_in),
        .checksum_ok    (in_ok_reg),
        .timeout_ticks  (timeout_reg),
        .state_cur      (state_reg),
        .tick_cur       (tick_reg),
        .reply_seq_cur  (reply_seq_reg),
        .expected_cur   (expected_reg),
        .state_next     (state_next),
        .tick_next      (tick_next),
        .reply_seq_next (reply_seq_next),
        .expected_next  (expected_next),
        .reply          (reply),
        .send_seq       (send_seq)
    );

    // Input register loads whenever it is empty or its item moves on.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_tick_reg <= s_tuser;
            in_type_reg <= s_tdata[2:0];
            in_seq_reg  <= s_tdata[18:3];
            in_ok_reg   <= s_tdata[19];
        end
    end

    // Connection state and timeout register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= gbnr_pkg::LS_LISTEN;
            tick_reg      <= '0;
            reply_seq_reg <= '0;
            expected_reg  <= '0;
            timeout_reg   <= gbnr_pkg::TIMEOUT_RESET;
        end else begin
            if (step) begin
                state_reg     <= state_next;
                tick_reg      <= tick_next;
                reply_seq_reg <= reply_seq_next;
                expected_reg  <= expected_next;
            end
            if (cfg_wr_en) begin
                timeout_reg <= cfg_wr_data;
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
        if (step) begin
            out_data_reg <= {reply.link_state, reply.deliver, send_seq16,
                             reply.send_type, reply.send_valid};
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the Go-Back-N receiver engine.
// Drives packet headers and timer ticks, predicts every result item and checks it.
// Depends on gbnr_pkg and go_back_n_receiver_engine.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Sequence numbers are 16 bits wide here, so plain 16-bit arithmetic wraps correctly.
    localparam int SEQ_W        = 16;
    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 6;
    localparam int DRAIN_CYCLES = 8;
    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 40;
    localparam int HOLD_AT_A    = 250;
    localparam int HOLD_AT_B    = 1000;
    localparam int PAUSE_AT     = 600;

    // Type codes outside the defined set.
    localparam logic [2:0] PKT_RSVD6 = 3'd6;
    localparam logic [2:0] PKT_RSVD7 = 3'd7;

    // One input item: a received header or a timer tick.
    typedef struct packed {
        logic        is_tick;
        logic [2:0]  ptype;
        logic [15:0] pseq;
        logic        csum_ok;
    } gbn_item_t;

    // One result item.
    typedef struct packed {
        logic                  send_valid;
        logic [2:0]            send_type;
        logic [15:0]           send_seq;
        logic                  deliver;
        gbnr_pkg::link_state_t link_state;
    } gbn_result_t;

    // Connection context kept by the predictor and by the stimulus planner.
    typedef struct packed {
        gbnr_pkg::link_state_t st;
        logic [15:0]           reply_seq;
        logic [15:0]           expect_seq;
        logic [7:0]            ticks;
    } link_ctx_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [7:0]  cfg_wr_data = 8'd0;
    logic        s_tvalid    = 1'b0;
    logic [23:0] s_tdata     = 24'd0;
    logic        s_tuser     = 1'b0;
    logic        m_tready    = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [23:0] m_tdata;

    gbn_item_t   hdr_q[$];
    gbn_result_t reply_q[$];
    gbn_item_t   cur_item;
    link_ctx_t   pred_ctx;
    link_ctx_t   plan_ctx;
    logic [7:0]  tmo_reg;
    logic        tx_pause    = 1'b0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          n_accepted  = 0;
    int          n_replies   = 0;
    int          n_delivered = 0;
    int          err_cnt     = 0;
    int          cycle_cnt   = 0;
    int          plan_cnt    = 0;
    int          hold_left   = 0;
    int          hold_stage  = 0;

    go_back_n_receiver_engine #(.SEQ_BITS(SEQ_W)) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    // Apply one item to a connection context and produce its result.
    task automatic advance_link(inout link_ctx_t ctx, input logic [7:0] tmo,
                                input gbn_item_t it, output gbn_result_t rep);
        logic [8:0] nxt;
        logic       resend;
        logic       valid_pkt;
        rep       = '0;
        resend    = 1'b0;
        valid_pkt = !it.is_tick && it.csum_ok;
        case (ctx.st)
            gbnr_pkg::LS_LISTEN: begin
                if (valid_pkt && it.ptype == gbnr_pkg::PKT_SYN) begin
                    ctx.reply_seq  = it.pseq + 16'd1;
                    rep.send_valid = 1'b1;
                    rep.send_type  = gbnr_pkg::PKT_SYNACK;
                    rep.send_seq   = ctx.reply_seq;
                    ctx.ticks      = 8'd0;
                    ctx.st         = gbnr_pkg::LS_WAIT_ACK;
                end
            end
            gbnr_pkg::LS_WAIT_ACK, gbnr_pkg::LS_WAIT_FINAL: begin
                if (it.is_tick) begin
                    // A zero timeout behaves like one: every tick expires.
                    nxt = {1'b0, ctx.ticks} + 9'd1;
                    if (nxt >= {1'b0, tmo}) begin
                        ctx.ticks = 8'd0;
                        resend    = 1'b1;
                    end else begin
                        ctx.ticks = nxt[7:0];
                    end
                end else if (valid_pkt && it.ptype == gbnr_pkg::PKT_ACK) begin
                    ctx.ticks = 8'd0;
                    if (ctx.st == gbnr_pkg::LS_WAIT_ACK) begin
                        ctx.st = gbnr_pkg::LS_ESTAB;
                    end else begin
                        ctx.st = gbnr_pkg::LS_CLOSED;
                    end
                end else begin
                    // Any other packet, valid or not, triggers a resend.
                    resend    = 1'b1;
                    ctx.ticks = 8'd0;
                end
                if (resend) begin
                    rep.send_valid = 1'b1;
                    rep.send_type  = (ctx.st == gbnr_pkg::LS_WAIT_ACK) ?
                                     gbnr_pkg::PKT_SYNACK : gbnr_pkg::PKT_FINACK;
                    rep.send_seq   = ctx.reply_seq;
                end
            end
            gbnr_pkg::LS_ESTAB: begin
                if (valid_pkt && it.ptype == gbnr_pkg::PKT_FIN) begin
                    ctx.reply_seq  = it.pseq + 16'd1;
                    rep.send_valid = 1'b1;
                    rep.send_type  = gbnr_pkg::PKT_FINACK;
                    rep.send_seq   = ctx.reply_seq;
                    ctx.ticks      = 8'd0;
                    ctx.st         = gbnr_pkg::LS_WAIT_FINAL;
                end else if (valid_pkt && it.ptype == gbnr_pkg::PKT_DATA) begin
                    rep.send_valid = 1'b1;
                    rep.send_type  = gbnr_pkg::PKT_ACK;
                    if (it.pseq == ctx.expect_seq) begin
                        ctx.expect_seq = ctx.expect_seq + 16'd1;
                        rep.deliver    = 1'b1;
                    end
                    rep.send_seq = ctx.expect_seq;
                end
            end
            default: begin
                // Closed for good: nothing is answered.
                ctx.st = gbnr_pkg::LS_CLOSED;
            end
        endcase
        rep.link_state = ctx.st;
    endtask

    function automatic gbn_item_t mk_item(input logic tick, input logic [2:0] ptype,
                                          input logic [15:0] pseq, input logic ok);
        gbn_item_t it;
        it.is_tick = tick;
        it.ptype   = ptype;
        it.pseq    = pseq;
        it.csum_ok = ok;
        return it;
    endfunction

    // Sequence numbers lean toward the extremes.
    function automatic logic [15:0] pick_seq();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'h0000;
        if (r == 1) return 16'hFFFF;
        return 16'($urandom);
    endfunction

    // Ticks carry random header content, which the block must ignore.
    function automatic gbn_item_t tick_item();
        return mk_item(1'b1, 3'($urandom_range(0, 7)), 16'($urandom),
                       1'($urandom_range(0, 1)));
    endfunction

    // Random header of any type; a valid one of type forbid is spoiled.
    function automatic gbn_item_t rand_pkt(input logic [2:0] forbid);
        gbn_item_t it;
        it = mk_item(1'b0, 3'($urandom_range(0, 7)), pick_seq(), 1'($urandom_range(0, 1)));
        if (it.ptype == forbid) it.csum_ok = 1'b0;
        return it;
    endfunction

    // Queue an item for the driver and track where it leaves the link.
    task automatic push_item(input gbn_item_t it);
        gbn_result_t unused_rep;
        advance_link(plan_ctx, tmo_reg, it, unused_rep);
        hdr_q.push_back(it);
        plan_cnt++;
    endtask

    task automatic wait_drained();
        while (hdr_q.size() != 0 || s_tvalid || reply_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_timeout(input logic [7:0] val);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        tmo_reg = val;
    endtask

    // One phase: new timeout, new idle rates, then random items steered toward target.
    task automatic run_phase(input logic [7:0] tmo, input gbnr_pkg::link_state_t target,
                             input int count, input int tx_pct, input int rx_pct);
        int          roll;
        int          burst;
        int          k;
        logic [15:0] oo_seq;
        wait_drained();
        set_timeout(tmo);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        plan_cnt    = 0;
        while (plan_cnt < count) begin
            roll = int'($urandom_range(0, 99));
            case (plan_ctx.st)
                gbnr_pkg::LS_LISTEN: begin
                    if (roll < 40) begin
                        push_item(mk_item(1'b0, gbnr_pkg::PKT_SYN, pick_seq(), 1'b1));
                    end else if (roll < 60) begin
                        push_item(tick_item());
                    end else begin
                        push_item(rand_pkt(gbnr_pkg::PKT_SYN));
                    end
                end
                gbnr_pkg::LS_WAIT_ACK, gbnr_pkg::LS_WAIT_FINAL: begin
                    if (target > plan_ctx.st && roll < 25) begin
                        push_item(mk_item(1'b0, gbnr_pkg::PKT_ACK, pick_seq(), 1'b1));
                    end else if (roll < 60) begin
                        // A run of ticks; half of the runs last one full timeout.
                        burst = (tmo == 8'd0) ? 1 : int'(tmo);
                        if ($urandom_range(0, 1) != 0) burst = int'($urandom_range(1, burst + 1));
                        for (k = 0; k < burst; k++) push_item(tick_item());
                    end else begin
                        push_item(rand_pkt(gbnr_pkg::PKT_ACK));
                    end
                end
                gbnr_pkg::LS_ESTAB: begin
                    if (target > gbnr_pkg::LS_ESTAB && roll < 15) begin
                        push_item(mk_item(1'b0, gbnr_pkg::PKT_FIN, pick_seq(), 1'b1));
                    end else if (roll < 60) begin
                        push_item(mk_item(1'b0, gbnr_pkg::PKT_DATA, plan_ctx.expect_seq,
                                          1'b1));
                    end else if (roll < 72) begin
                        case ($urandom_range(0, 2))
                            0: oo_seq = plan_ctx.expect_seq + 16'd1;
                            1: oo_seq = plan_ctx.expect_seq - 16'd1;
                            default: oo_seq = pick_seq();
                        endcase
                        if (oo_seq == plan_ctx.expect_seq) oo_seq = oo_seq ^ 16'h8000;
                        push_item(mk_item(1'b0, gbnr_pkg::PKT_DATA, oo_seq, 1'b1));
                    end else if (roll < 80) begin
                        push_item(tick_item());
                    end else if (roll < 87) begin
                        push_item(mk_item(1'b0, gbnr_pkg::PKT_DATA, plan_ctx.expect_seq,
                                          1'b0));
                    end else begin
                        push_item(rand_pkt(gbnr_pkg::PKT_FIN));
                    end
                end
                default: begin
                    if (roll < 30) begin
                        push_item(tick_item());
                    end else begin
                        push_item(rand_pkt(PKT_RSVD7));
                    end
                end
            endcase
        end
    endtask

    task automatic check_field(input string fname, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
        end
    endtask

    // Run limit.
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, reply_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Driver: predicts on each accepted item, then offers the next one or idles.
    always @(posedge aclk) begin : drv_proc
        gbn_result_t want;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                advance_link(pred_ctx, tmo_reg, cur_item, want);
                reply_q.push_back(want);
                n_accepted++;
                if (n_accepted == PAUSE_AT) tx_pause = 1'b1;
            end
            if (tx_pause && reply_q.size() == 0) tx_pause = 1'b0;
            if (s_tvalid && !s_tready) begin
                // Keep offering the same item until it is taken.
            end else if (!tx_pause && hdr_q.size() != 0 &&
                         $urandom_range(0, 99) >= tx_idle_pct) begin
                cur_item = hdr_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {4'd0, cur_item.csum_ok, cur_item.pseq, cur_item.ptype};
                s_tuser  <= cur_item.is_tick;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: checks each accepted result and drives m_tready, with two long hold-offs.
    always @(posedge aclk) begin : mon_proc
        gbn_result_t want;
        gbn_result_t got;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = {m_tdata[0], m_tdata[3:1], m_tdata[19:4], m_tdata[20], m_tdata[23:21]};
                if (reply_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected result item %h", $time, m_tdata);
                end else begin
                    want = reply_q.pop_front();
                    check_field("send_valid", 32'(want.send_valid), 32'(got.send_valid));
                    check_field("send_type", 32'(want.send_type), 32'(got.send_type));
                    check_field("send_seq", 32'(want.send_seq), 32'(got.send_seq));
                    check_field("deliver", 32'(want.deliver), 32'(got.deliver));
                    check_field("link_state", 32'(want.link_state), 32'(got.link_state));
                    if (got.send_valid) n_replies++;
                    if (got.deliver) n_delivered++;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if ((hold_stage == 0 && n_accepted >= HOLD_AT_A) ||
                         (hold_stage == 1 && n_accepted >= HOLD_AT_B)) begin
                hold_stage++;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Stimulus sequence and final verdict.
    initial begin : stim_proc
        pred_ctx    = '0;
        pred_ctx.st = gbnr_pkg::LS_LISTEN;
        plan_ctx    = pred_ctx;
        tmo_reg     = gbnr_pkg::TIMEOUT_RESET;
        tx_idle_pct = 22;
        rx_idle_pct = 69;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Listening: tick, stray data, bad SYN, reserved type and a stray SYNACK are ignored.
        push_item(mk_item(1'b1, gbnr_pkg::PKT_SYN, 16'h0000, 1'b1));
        push_item(mk_item(1'b0, gbnr_pkg::PKT_DATA, 16'h0000, 1'b1));
        push_item(mk_item(1'b0, gbnr_pkg::PKT_SYN, 16'h1234, 1'b0));
        push_item(mk_item(1'b0, PKT_RSVD7, 16'hFFFF, 1'b1));
        push_item(mk_item(1'b0, gbnr_pkg::PKT_SYNACK, 16'hFFFF, 1'b1));
        // SYN at the top of the range: the SYNACK number wraps to zero.
        push_item(mk_item(1'b0, gbnr_pkg::PKT_SYN, 16'hFFFF, 1'b1));
        // Reset timeout of five: four silent ticks, the fifth resends.
        repeat (5) push_item(mk_item(1'b1, gbnr_pkg::PKT_DATA, 16'hFFFF, 1'b0));
        // Other packets while waiting for the ACK resend the SYNACK; the tick among them stays silent.
        push_item(mk_item(1'b0, gbnr_pkg::PKT_DATA, 16'h0000, 1'b1));
        push_item(mk_item(1'b0, gbnr_pkg::PKT_ACK, 16'h0000, 1'b0));
        push_item(mk_item(1'b0, PKT_RSVD6, 16'h8000, 1'b1));
        push_item(mk_item(1'b1, gbnr_pkg::PKT_ACK, 16'h0001, 1'b1));
        push_item(mk_item(1'b0, gbnr_pkg::PKT_SYN, 16'h1234, 1'b1));

        run_phase(8'd1, gbnr_pkg::LS_WAIT_ACK, 120, 22, 69);
        run_phase(8'd0, gbnr_pkg::LS_WAIT_ACK, 60, 22, 69);
        run_phase(8'($urandom_range(2, 20)), gbnr_pkg::LS_ESTAB, 250, 22, 69);
        run_phase(8'd255, gbnr_pkg::LS_ESTAB, 200, 69, 22);
        run_phase(8'd3, gbnr_pkg::LS_ESTAB, 150, 69, 22);
        run_phase(8'd2, gbnr_pkg::LS_WAIT_FINAL, 100, 0, 0);
        run_phase(8'd255, gbnr_pkg::LS_WAIT_FINAL, 150, 0, 0);
        run_phase(8'($urandom_range(1, 254)), gbnr_pkg::LS_CLOSED, 40, 0, 0);
        wait_drained();

        $display("Ran %0d items through handshake, data transfer, close and closed link,",
                 n_accepted);
        $display("with %0d replies and %0d in-order deliveries checked.",
                 n_replies, n_delivered);
        if (err_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== go_back_n_receiver_engine.f =====
rtl/gbnr_pkg.sv
rtl/gbnr_core.sv
rtl/go_back_n_receiver_engine.sv
tb/tb_top.sv
